// ===== src/gcg_pkg.sv =====
// Shared constants and types of the glimpse crop gather core.
`timescale 1ns / 1ps

package gcg_pkg;

  localparam int unsigned IMAGE_WORDS   = 65536;
  localparam bit          CHANNEL_FIRST = 1'b0;
  localparam int unsigned ADDR_W        = $clog2(IMAGE_WORDS);

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned EXT_W      = 9;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned LOAD_W     = 16;

  localparam int unsigned A1_W = 2 * EXT_W + 1;
  localparam int unsigned A2_W = A1_W + EXT_W;
  localparam int unsigned A3_W = A2_W + EXT_W;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_LENGTH  = 4'd0,
    CFG_IMAGE_HEIGHT  = 4'd1,
    CFG_IMAGE_WIDTH   = 4'd2,
    CFG_CHANNEL_COUNT = 4'd3,
    CFG_WINDOW_LENGTH = 4'd4,
    CFG_WINDOW_HEIGHT = 4'd5,
    CFG_WINDOW_WIDTH  = 4'd6,
    CFG_STEP_SIZE     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                     mode;
    logic [LOAD_W-1:0]        load_address;
    logic signed [DATA_W-1:0] load_value;
    logic [CHAN_W-1:0]        channel_index;
  } item_t;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] center_depth;
    logic signed [COORD_IN_W-1:0] center_row;
    logic signed [COORD_IN_W-1:0] center_col;
    logic [IDX_W-1:0]             win_depth_index;
    logic [IDX_W-1:0]             win_row_index;
    logic [IDX_W-1:0]             win_col_index;
  } query_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pixel_value;
    logic                     out_of_range;
  } result_t;

endpackage

// ===== src/gcg_if.sv =====
// Handshake channel interfaces of the glimpse crop gather core.
`timescale 1ns / 1ps

interface gcg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gcg_pkg::CFG_IDX_W-1:0]       index;
  logic [gcg_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface gcg_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic [gcg_pkg::LOAD_W-1:0]              load_address;
  logic signed [gcg_pkg::DATA_W-1:0]       load_value;
  logic signed [gcg_pkg::COORD_IN_W-1:0]   center_depth;
  logic signed [gcg_pkg::COORD_IN_W-1:0]   center_row;
  logic signed [gcg_pkg::COORD_IN_W-1:0]   center_col;
  logic [gcg_pkg::IDX_W-1:0]               win_depth_index;
  logic [gcg_pkg::IDX_W-1:0]               win_row_index;
  logic [gcg_pkg::IDX_W-1:0]               win_col_index;
  logic [gcg_pkg::CHAN_W-1:0]              channel_index;

  modport source (
    output valid, output mode, output load_address, output load_value,
    output center_depth, output center_row, output center_col,
    output win_depth_index, output win_row_index, output win_col_index,
    output channel_index, input ready
  );
  modport sink (
    input valid, input mode, input load_address, input load_value,
    input center_depth, input center_row, input center_col,
    input win_depth_index, input win_row_index, input win_col_index,
    input channel_index, output ready
  );
endinterface

interface gcg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gcg_pkg::DATA_W-1:0] pixel_value;
  logic                              out_of_range;

  modport source (output valid, output pixel_value, output out_of_range, input ready);
  modport sink (input valid, input pixel_value, input out_of_range, output ready);
endinterface

// ===== src/gcg_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module gcg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gcg_axis.sv =====
// Two-stage window offset and edge clamp of one sampling axis.
`timescale 1ns / 1ps

module gcg_axis (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [gcg_pkg::COORD_IN_W-1:0]  center_i,
  input  logic [gcg_pkg::WIN_W-1:0]              win_i,
  input  logic [gcg_pkg::IDX_W-1:0]              idx_i,
  input  logic [gcg_pkg::STEP_W-1:0]             step_i,
  input  logic [gcg_pkg::EXT_W-1:0]              extent_i,
  output logic [gcg_pkg::EXT_W-1:0]              coord_o
);

  localparam int unsigned OFFS_W = gcg_pkg::IDX_W + 2;
  localparam int unsigned PROD_W = OFFS_W + gcg_pkg::STEP_W + 1;
  localparam int unsigned POS_W  = gcg_pkg::COORD_IN_W + 2;

  logic signed [OFFS_W-1:0]              offs;
  logic signed [PROD_W-1:0]              prod_d, prod_q;
  logic signed [gcg_pkg::COORD_IN_W-1:0] center_q;
  logic signed [POS_W-1:0]               pos;
  logic [gcg_pkg::EXT_W-1:0]             coord_d, coord_q;

  assign offs   = $signed({2'b00, win_i[gcg_pkg::WIN_W-1:1]}) - $signed({2'b00, idx_i});
  assign prod_d = offs * $signed({1'b0, step_i});
  assign pos    = center_q - prod_q;

  always_comb begin
    if (pos[POS_W-1]) begin
      coord_d = '0;
    end else if (pos >= $signed({{(POS_W - gcg_pkg::EXT_W){1'b0}}, extent_i})) begin
      coord_d = extent_i - gcg_pkg::EXT_W'(1);
    end else begin
      coord_d = pos[gcg_pkg::EXT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      center_q <= center_i;
      coord_q  <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

// ===== src/gcg_addr.sv =====
// Three-stage multiply-add chain that flattens a sample position into a word address.
`timescale 1ns / 1ps

module gcg_addr (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gcg_pkg::EXT_W-1:0]     p0_i,
  input  logic [gcg_pkg::EXT_W-1:0]     k0_i,
  input  logic [gcg_pkg::EXT_W-1:0]     q0_i,
  input  logic [gcg_pkg::EXT_W-1:0]     k1_i,
  input  logic [gcg_pkg::EXT_W-1:0]     q1_i,
  input  logic [gcg_pkg::EXT_W-1:0]     k2_i,
  input  logic [gcg_pkg::EXT_W-1:0]     q2_i,
  output logic [gcg_pkg::A3_W-1:0]      addr_o
);

  logic [gcg_pkg::A1_W-1:0]  a1_d, a1_q;
  logic [gcg_pkg::A2_W-1:0]  a2_d, a2_q;
  logic [gcg_pkg::A3_W-1:0]  a3_d, a3_q;
  logic [gcg_pkg::EXT_W-1:0] q1_q, q2_q, q2_qq;

  assign a1_d = gcg_pkg::A1_W'(p0_i) * gcg_pkg::A1_W'(k0_i) + gcg_pkg::A1_W'(q0_i);
  assign a2_d = gcg_pkg::A2_W'(a1_q) * gcg_pkg::A2_W'(k1_i) + gcg_pkg::A2_W'(q1_q);
  assign a3_d = gcg_pkg::A3_W'(a2_q) * gcg_pkg::A3_W'(k2_i) + gcg_pkg::A3_W'(q2_qq);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a1_d;
      q1_q  <= q1_i;
      q2_q  <= q2_i;
      a2_q  <= a2_d;
      q2_qq <= q2_q;
      a3_q  <= a3_d;
    end
  end

  assign addr_o = a3_q;

endmodule

// ===== src/glimpse_crop_clamped_gather_core.sv =====
// Top level of the glimpse crop gather core: config registers, pipeline, image RAM, output skid.
// A query beat passes through the input register, 2 clamp stages, 3 address multiply-add
// stages, the RAM access and the output register. Throughput: one load or query beat per
// cycle unless the skid register is full; the single image RAM does one write or one read
// per cycle at the access stage, so loads and queries keep their order.
// Reset clears all valid flags and sets every config register to 1; the image RAM is not
// cleared, and a word never loaded reads as an unknown value.
`timescale 1ns / 1ps

module glimpse_crop_clamped_gather_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcg_cfg_if.sink   cfg_i,
  gcg_in_if.sink    in_i,
  gcg_out_if.source out_o
);

  localparam int unsigned STAGES = 6;

  logic [gcg_pkg::EXT_W-1:0]  image_length_q, image_height_q, image_width_q;
  logic [gcg_pkg::CH_W-1:0]   channel_count_q;
  logic [gcg_pkg::WIN_W-1:0]  window_length_q, window_height_q, window_width_q;
  logic [gcg_pkg::STEP_W-1:0] step_size_q;

  logic [gcg_pkg::EXT_W-1:0]  len_e, hgt_e, wid_e, chn_e;

  logic                       en;
  logic [STAGES-1:0]          v_q;
  gcg_pkg::item_t             item_q [STAGES];
  gcg_pkg::query_t            query_q;

  logic [gcg_pkg::EXT_W-1:0]  coord_d, coord_r, coord_x, chan_ext;
  logic [gcg_pkg::EXT_W-1:0]  p0, k0, q0, k1, q1, k2, q2;
  logic [gcg_pkg::A3_W-1:0]   addr;

  logic                       is_query, oor, ram_we, ram_re;
  logic [gcg_pkg::DATA_W-1:0] ram_rdata;

  logic                       vr_q, oor_r_q, push;
  gcg_pkg::result_t           res_r, out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_length_q  <= gcg_pkg::EXT_W'(1);
      image_height_q  <= gcg_pkg::EXT_W'(1);
      image_width_q   <= gcg_pkg::EXT_W'(1);
      channel_count_q <= gcg_pkg::CH_W'(1);
      window_length_q <= gcg_pkg::WIN_W'(1);
      window_height_q <= gcg_pkg::WIN_W'(1);
      window_width_q  <= gcg_pkg::WIN_W'(1);
      step_size_q     <= gcg_pkg::STEP_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        gcg_pkg::CFG_IMAGE_LENGTH:  image_length_q  <= cfg_i.data[gcg_pkg::EXT_W-1:0];
        gcg_pkg::CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_i.data[gcg_pkg::EXT_W-1:0];
        gcg_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_i.data[gcg_pkg::EXT_W-1:0];
        gcg_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_i.data[gcg_pkg::CH_W-1:0];
        gcg_pkg::CFG_WINDOW_LENGTH: window_length_q <= cfg_i.data[gcg_pkg::WIN_W-1:0];
        gcg_pkg::CFG_WINDOW_HEIGHT: window_height_q <= cfg_i.data[gcg_pkg::WIN_W-1:0];
        gcg_pkg::CFG_WINDOW_WIDTH:  window_width_q  <= cfg_i.data[gcg_pkg::WIN_W-1:0];
        gcg_pkg::CFG_STEP_SIZE:     step_size_q     <= cfg_i.data[gcg_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // A zero extent behaves as an extent of one.
  assign len_e = (image_length_q == '0) ? gcg_pkg::EXT_W'(1) : image_length_q;
  assign hgt_e = (image_height_q == '0) ? gcg_pkg::EXT_W'(1) : image_height_q;
  assign wid_e = (image_width_q == '0) ? gcg_pkg::EXT_W'(1) : image_width_q;
  assign chn_e = (channel_count_q == '0) ? gcg_pkg::EXT_W'(1)
                                         : gcg_pkg::EXT_W'(channel_count_q);

  // The whole pipeline moves together and stops only when the skid register is full.
  assign en         = !skid_valid_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[STAGES-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q[0] <= '{mode:          in_i.mode,
                     load_address:  in_i.load_address,
                     load_value:    in_i.load_value,
                     channel_index: in_i.channel_index};
      query_q   <= '{center_depth:    in_i.center_depth,
                     center_row:      in_i.center_row,
                     center_col:      in_i.center_col,
                     win_depth_index: in_i.win_depth_index,
                     win_row_index:   in_i.win_row_index,
                     win_col_index:   in_i.win_col_index};
      for (int i = 1; i < STAGES; i++) begin
        item_q[i] <= item_q[i-1];
      end
    end
  end

  gcg_axis u_axis_depth (
    .clk_i    (clk_i),
    .en_i     (en),
    .center_i (query_q.center_depth),
    .win_i    (window_length_q),
    .idx_i    (query_q.win_depth_index),
    .step_i   (step_size_q),
    .extent_i (len_e),
    .coord_o  (coord_d)
  );

  gcg_axis u_axis_row (
    .clk_i    (clk_i),
    .en_i     (en),
    .center_i (query_q.center_row),
    .win_i    (window_height_q),
    .idx_i    (query_q.win_row_index),
    .step_i   (step_size_q),
    .extent_i (hgt_e),
    .coord_o  (coord_r)
  );

  gcg_axis u_axis_col (
    .clk_i    (clk_i),
    .en_i     (en),
    .center_i (query_q.center_col),
    .win_i    (window_width_q),
    .idx_i    (query_q.win_col_index),
    .step_i   (step_size_q),
    .extent_i (wid_e),
    .coord_o  (coord_x)
  );

  assign chan_ext = gcg_pkg::EXT_W'(item_q[2].channel_index);

  assign p0 = gcg_pkg::CHANNEL_FIRST ? chan_ext : coord_d;
  assign k0 = gcg_pkg::CHANNEL_FIRST ? len_e    : hgt_e;
  assign q0 = gcg_pkg::CHANNEL_FIRST ? coord_d  : coord_r;
  assign k1 = gcg_pkg::CHANNEL_FIRST ? hgt_e    : wid_e;
  assign q1 = gcg_pkg::CHANNEL_FIRST ? coord_r  : coord_x;
  assign k2 = gcg_pkg::CHANNEL_FIRST ? wid_e    : chn_e;
  assign q2 = gcg_pkg::CHANNEL_FIRST ? coord_x  : chan_ext;

  gcg_addr u_addr (
    .clk_i  (clk_i),
    .en_i   (en),
    .p0_i   (p0),
    .k0_i   (k0),
    .q0_i   (q0),
    .k1_i   (k1),
    .q1_i   (q1),
    .k2_i   (k2),
    .q2_i   (q2),
    .addr_o (addr)
  );

  // Loads and queries reach the RAM in arrival order, so a write lands before any later read.
  assign is_query = (item_q[STAGES-1].mode == gcg_pkg::MODE_QUERY);
  assign oor      = (addr >= gcg_pkg::A3_W'(gcg_pkg::IMAGE_WORDS));
  assign ram_re   = en && v_q[STAGES-1] && is_query && !oor;
  assign ram_we   = en && v_q[STAGES-1] && !is_query
                 && (gcg_pkg::A3_W'(item_q[STAGES-1].load_address)
                     < gcg_pkg::A3_W'(gcg_pkg::IMAGE_WORDS));

  gcg_ram #(
    .WIDTH (gcg_pkg::DATA_W),
    .DEPTH (gcg_pkg::IMAGE_WORDS)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (gcg_pkg::ADDR_W'(item_q[STAGES-1].load_address)),
    .wdata_i (item_q[STAGES-1].load_value),
    .re_i    (ram_re),
    .raddr_i (addr[gcg_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en) begin
      vr_q <= v_q[STAGES-1] && is_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_r_q <= oor;
    end
  end

  assign res_r.pixel_value  = oor_r_q ? '0 : ram_rdata;
  assign res_r.out_of_range = oor_r_q;
  assign push               = en && vr_q;

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_q <= skid_valid_q ? skid_q : res_r;
    end else if (push) begin
      skid_q <= res_r;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_value  = out_q.pixel_value;
  assign out_o.out_of_range = out_q.out_of_range;

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready))
    else $error("skid register filled while the output beat was not stalled");

  a_ram_idle_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (!ram_we && !ram_re))
    else $error("image RAM accessed while the pipeline is held");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted beat did not enter the first stage");

  a_oor_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_of_range) |-> (out_q.pixel_value == '0))
    else $error("out-of-range result carries a nonzero pixel");

endmodule

// ===== dv/tb_glimpse_crop_clamped_gather_core.sv =====
// Self-checking testbench for the glimpse crop gather core with replicate padding.
`timescale 1ns / 1ps

module tb_glimpse_crop_clamped_gather_core;

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef struct packed {
    logic                                  mode;
    logic [gcg_pkg::LOAD_W-1:0]            load_address;
    logic signed [gcg_pkg::DATA_W-1:0]     load_value;
    logic signed [gcg_pkg::COORD_IN_W-1:0] center_depth;
    logic signed [gcg_pkg::COORD_IN_W-1:0] center_row;
    logic signed [gcg_pkg::COORD_IN_W-1:0] center_col;
    logic [gcg_pkg::IDX_W-1:0]             win_depth_index;
    logic [gcg_pkg::IDX_W-1:0]             win_row_index;
    logic [gcg_pkg::IDX_W-1:0]             win_col_index;
    logic [gcg_pkg::CHAN_W-1:0]            channel_index;
  } gather_req_t;

  logic clk_i;
  logic rst_ni;

  gcg_cfg_if cfg_if ();
  gcg_in_if  in_if ();
  gcg_out_if out_if ();

  glimpse_crop_clamped_gather_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [gcg_pkg::EXT_W-1:0]  img_len;
  logic [gcg_pkg::EXT_W-1:0]  img_hgt;
  logic [gcg_pkg::EXT_W-1:0]  img_wid;
  logic [gcg_pkg::CH_W-1:0]   chan_cnt;
  logic [gcg_pkg::WIN_W-1:0]  win_len;
  logic [gcg_pkg::WIN_W-1:0]  win_hgt;
  logic [gcg_pkg::WIN_W-1:0]  win_wid;
  logic [gcg_pkg::STEP_W-1:0] step_size;

  logic [gcg_pkg::DATA_W-1:0] image_copy [gcg_pkg::IMAGE_WORDS];
  bit                         word_loaded [gcg_pkg::IMAGE_WORDS];
  gcg_pkg::result_t           pixel_queue [$];

  int unsigned mismatch_count;
  int unsigned stall_cycles;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned nonzero(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned clamp_axis(
      logic signed [gcg_pkg::COORD_IN_W-1:0] centre, logic [gcg_pkg::WIN_W-1:0] win,
      logic [gcg_pkg::IDX_W-1:0] idx, longint unsigned extent);
    longint pos;
    pos = longint'(centre) - (longint'(win >> 1) - longint'(idx)) * longint'(step_size);
    if (pos < 0) pos = 0;
    if (pos >= longint'(extent)) pos = longint'(extent) - 1;
    return longint'(pos);
  endfunction

  function automatic longint unsigned word_index(gather_req_t req);
    longint unsigned l_e, h_e, w_e, c_e, d, r, x, c;
    l_e = nonzero(64'(img_len));
    h_e = nonzero(64'(img_hgt));
    w_e = nonzero(64'(img_wid));
    c_e = nonzero(64'(chan_cnt));
    d = clamp_axis(req.center_depth, win_len, req.win_depth_index, l_e);
    r = clamp_axis(req.center_row, win_hgt, req.win_row_index, h_e);
    x = clamp_axis(req.center_col, win_wid, req.win_col_index, w_e);
    c = 64'(req.channel_index);
    if (gcg_pkg::CHANNEL_FIRST) return ((c * l_e + d) * h_e + r) * w_e + x;
    return ((d * h_e + r) * w_e + x) * c_e + c;
  endfunction

  function automatic gather_req_t random_req();
    gather_req_t req;
    req.mode            = 1'($urandom_range(1));
    req.load_address    = gcg_pkg::LOAD_W'($urandom_range(65535));
    req.load_value      = gcg_pkg::DATA_W'($urandom_range(65535));
    req.center_depth    = gcg_pkg::COORD_IN_W'($urandom_range(65535));
    req.center_row      = gcg_pkg::COORD_IN_W'($urandom_range(65535));
    req.center_col      = gcg_pkg::COORD_IN_W'($urandom_range(65535));
    req.win_depth_index = gcg_pkg::IDX_W'($urandom_range(63));
    req.win_row_index   = gcg_pkg::IDX_W'($urandom_range(63));
    req.win_col_index   = gcg_pkg::IDX_W'($urandom_range(63));
    req.channel_index   = gcg_pkg::CHAN_W'($urandom_range(15));
    return req;
  endfunction

  function automatic logic signed [gcg_pkg::COORD_IN_W-1:0] pick_centre(
      longint unsigned extent);
    if ($urandom_range(99) < 20) return gcg_pkg::COORD_IN_W'($urandom_range(65535));
    return gcg_pkg::COORD_IN_W'(int'($urandom_range(32'(extent) + 32'd15)) - 8);
  endfunction

  function automatic logic [gcg_pkg::IDX_W-1:0] pick_index(logic [gcg_pkg::WIN_W-1:0] win);
    if (win == 0 || win > 64 || $urandom_range(99) < 15) begin
      return gcg_pkg::IDX_W'($urandom_range(63));
    end
    return gcg_pkg::IDX_W'($urandom_range(32'(win) - 32'd1));
  endfunction

  function automatic logic [gcg_pkg::CHAN_W-1:0] pick_channel();
    if (chan_cnt == 0 || chan_cnt > 16 || $urandom_range(99) < 15) begin
      return gcg_pkg::CHAN_W'($urandom_range(15));
    end
    return gcg_pkg::CHAN_W'($urandom_range(32'(chan_cnt) - 32'd1));
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic send_item(gather_req_t req);
    longint unsigned  addr;
    gcg_pkg::result_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= req.mode;
    in_if.load_address    <= req.load_address;
    in_if.load_value      <= req.load_value;
    in_if.center_depth    <= req.center_depth;
    in_if.center_row      <= req.center_row;
    in_if.center_col      <= req.center_col;
    in_if.win_depth_index <= req.win_depth_index;
    in_if.win_row_index   <= req.win_row_index;
    in_if.win_col_index   <= req.win_col_index;
    in_if.channel_index   <= req.channel_index;
    do @(posedge clk_i); while (!in_if.ready);
    if (req.mode == gcg_pkg::MODE_LOAD) begin
      if (req.load_address < gcg_pkg::IMAGE_WORDS) begin
        image_copy[req.load_address]  = req.load_value;
        word_loaded[req.load_address] = 1'b1;
      end
    end else begin
      addr = word_index(req);
      if (addr < gcg_pkg::IMAGE_WORDS) begin
        want.pixel_value  = image_copy[addr[gcg_pkg::ADDR_W-1:0]];
        want.out_of_range = 1'b0;
      end else begin
        want.pixel_value  = '0;
        want.out_of_range = 1'b1;
      end
      pixel_queue.push_back(want);
    end
  endtask

  // A query that would hit a word never loaded gets that word loaded first.
  task automatic send_query(gather_req_t req);
    longint unsigned addr;
    gather_req_t     fill;
    addr = word_index(req);
    if (addr < gcg_pkg::IMAGE_WORDS && !word_loaded[addr[gcg_pkg::ADDR_W-1:0]]) begin
      fill = random_req();
      fill.mode = gcg_pkg::MODE_LOAD;
      fill.load_address = addr[gcg_pkg::LOAD_W-1:0];
      send_item(fill);
    end
    send_item(req);
  endtask

  task automatic load_word(logic [gcg_pkg::LOAD_W-1:0] addr,
                           logic signed [gcg_pkg::DATA_W-1:0] value);
    gather_req_t req;
    req = random_req();
    req.mode = gcg_pkg::MODE_LOAD;
    req.load_address = addr;
    req.load_value = value;
    send_item(req);
  endtask

  task automatic ask(logic signed [gcg_pkg::COORD_IN_W-1:0] cd,
                     logic signed [gcg_pkg::COORD_IN_W-1:0] cr,
                     logic signed [gcg_pkg::COORD_IN_W-1:0] cc,
                     logic [gcg_pkg::IDX_W-1:0] id, logic [gcg_pkg::IDX_W-1:0] ir,
                     logic [gcg_pkg::IDX_W-1:0] ic, logic [gcg_pkg::CHAN_W-1:0] ch);
    gather_req_t req;
    req = random_req();
    req.mode = gcg_pkg::MODE_QUERY;
    req.center_depth = cd;
    req.center_row = cr;
    req.center_col = cc;
    req.win_depth_index = id;
    req.win_row_index = ir;
    req.win_col_index = ic;
    req.channel_index = ch;
    send_query(req);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(gcg_pkg::cfg_reg_e idx, logic [gcg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      gcg_pkg::CFG_IMAGE_LENGTH:  img_len = value[gcg_pkg::EXT_W-1:0];
      gcg_pkg::CFG_IMAGE_HEIGHT:  img_hgt = value[gcg_pkg::EXT_W-1:0];
      gcg_pkg::CFG_IMAGE_WIDTH:   img_wid = value[gcg_pkg::EXT_W-1:0];
      gcg_pkg::CFG_CHANNEL_COUNT: chan_cnt = value[gcg_pkg::CH_W-1:0];
      gcg_pkg::CFG_WINDOW_LENGTH: win_len = value[gcg_pkg::WIN_W-1:0];
      gcg_pkg::CFG_WINDOW_HEIGHT: win_hgt = value[gcg_pkg::WIN_W-1:0];
      gcg_pkg::CFG_WINDOW_WIDTH:  win_wid = value[gcg_pkg::WIN_W-1:0];
      gcg_pkg::CFG_STEP_SIZE:     step_size = value[gcg_pkg::STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(logic [gcg_pkg::CFG_DATA_W-1:0] l,
                           logic [gcg_pkg::CFG_DATA_W-1:0] h,
                           logic [gcg_pkg::CFG_DATA_W-1:0] w,
                           logic [gcg_pkg::CFG_DATA_W-1:0] c,
                           logic [gcg_pkg::CFG_DATA_W-1:0] wl,
                           logic [gcg_pkg::CFG_DATA_W-1:0] wh,
                           logic [gcg_pkg::CFG_DATA_W-1:0] ww,
                           logic [gcg_pkg::CFG_DATA_W-1:0] s);
    drain_results();
    write_reg(gcg_pkg::CFG_IMAGE_LENGTH, l);
    write_reg(gcg_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(gcg_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(gcg_pkg::CFG_CHANNEL_COUNT, c);
    write_reg(gcg_pkg::CFG_WINDOW_LENGTH, wl);
    write_reg(gcg_pkg::CFG_WINDOW_HEIGHT, wh);
    write_reg(gcg_pkg::CFG_WINDOW_WIDTH, ww);
    write_reg(gcg_pkg::CFG_STEP_SIZE, s);
  endtask

  task automatic run_random(int unsigned count, bit flat);
    gather_req_t req;
    for (int unsigned n = 0; n < count; n++) begin
      req = random_req();
      if ($urandom_range(99) < 20) begin
        req.mode = gcg_pkg::MODE_LOAD;
        if ($urandom_range(1)) req.load_address = gcg_pkg::LOAD_W'($urandom_range(1023));
        send_item(req);
      end else begin
        req.mode = gcg_pkg::MODE_QUERY;
        req.center_depth = flat ? '0 : pick_centre(nonzero(64'(img_len)));
        req.center_row = pick_centre(nonzero(64'(img_hgt)));
        req.center_col = pick_centre(nonzero(64'(img_wid)));
        req.win_depth_index = pick_index(win_len);
        req.win_row_index = pick_index(win_hgt);
        req.win_col_index = pick_index(win_wid);
        req.channel_index = pick_channel();
        send_query(req);
      end
    end
  endtask

  task automatic test_reset_defaults();
    load_word(16'd0, 16'sh8000);
    load_word(16'hFFFF, 16'sh7FFF);
    load_word(16'd15, 16'sh5A5A);
    ask(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd63, 6'd63, 6'd63, 4'd15);
    ask(16'sh8000, 16'sh8000, 16'sh8000, 6'd0, 6'd0, 6'd0, 4'd0);
    ask(16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0, 6'd0, 4'd7);
    ask(16'sd1, -16'sd1, 16'sd0, 6'd21, 6'd42, 6'd0, 4'd10);
  endtask

  task automatic test_edge_cases();
    configure(9'd256, 9'd256, 9'd256, 9'd16, 9'd64, 9'd64, 9'd64, 9'd16);
    ask(16'sd0, 16'sd0, 16'sd0, 6'd32, 6'd32, 6'd32, 4'd3);
    ask(16'sd0, 16'sd15, 16'sd255, 6'd32, 6'd32, 6'd32, 4'd15);
    ask(16'sd0, 16'sd16, 16'sd0, 6'd32, 6'd32, 6'd32, 4'd0);
    ask(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd63, 6'd63, 6'd63, 4'd15);
    ask(16'sh8000, 16'sh8000, 16'sh8000, 6'd0, 6'd0, 6'd0, 4'd0);
    // Zero extents act as one, and a zero step samples the clamped centre.
    configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    ask(16'sd5, -16'sd3, 16'sd7, 6'd63, 6'd0, 6'd40, 4'd9);
    ask(-16'sd1, -16'sd1, -16'sd1, 6'd0, 6'd0, 6'd0, 4'd15);
  endtask

  task automatic test_crop_2d();
    configure(9'd1, 9'd16, 9'd20, 9'd3, 9'd1, 9'd5, 9'd7, 9'd2);
    run_random(300, 1'b1);
  endtask

  task automatic test_volume_3d();
    configure(9'd8, 9'd12, 9'd10, 9'd4, 9'd3, 9'd4, 9'd5, 9'd1);
    steady = 1'b1;
    run_random(100, 1'b0);
    steady = 1'b0;
    run_random(100, 1'b0);
    drain_results();
    run_random(100, 1'b0);
  endtask

  task automatic test_oversized_registers();
    configure(9'h000, 9'h1FF, 9'd40, 9'h1FF, 9'h1FF, 9'd3, 9'h1FF, 9'h1FF);
    run_random(250, 1'b0);
  endtask

  task automatic test_zero_step();
    configure(9'd4, 9'd9, 9'd11, 9'd5, 9'd2, 9'd9, 9'd6, 9'd0);
    run_random(200, 1'b0);
  endtask

  task automatic test_largest_volume();
    configure(9'd256, 9'd256, 9'd256, 9'd16, 9'd64, 9'd64, 9'd64, 9'd16);
    run_random(300, 1'b0);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin : check_results
    gcg_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, pixel %0d out_of_range %0b",
                                  out_if.pixel_value, out_if.out_of_range));
      end else begin
        want = pixel_queue.pop_front();
        if (out_if.pixel_value !== want.pixel_value)
          report_mismatch($sformatf("pixel_value %0d, expected %0d",
                                    out_if.pixel_value, want.pixel_value));
        if (out_if.out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                    out_if.out_of_range, want.out_of_range));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    steady = 1'b0;
    mismatch_count = 0;
    stall_cycles = 0;
    img_len = gcg_pkg::EXT_W'(1);
    img_hgt = gcg_pkg::EXT_W'(1);
    img_wid = gcg_pkg::EXT_W'(1);
    chan_cnt = gcg_pkg::CH_W'(1);
    win_len = gcg_pkg::WIN_W'(1);
    win_hgt = gcg_pkg::WIN_W'(1);
    win_wid = gcg_pkg::WIN_W'(1);
    step_size = gcg_pkg::STEP_W'(1);
    cfg_if.valid = 1'b0;
    cfg_if.index = gcg_pkg::CFG_IMAGE_LENGTH;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.mode = gcg_pkg::MODE_LOAD;
    in_if.load_address = '0;
    in_if.load_value = '0;
    in_if.center_depth = '0;
    in_if.center_row = '0;
    in_if.center_col = '0;
    in_if.win_depth_index = '0;
    in_if.win_row_index = '0;
    in_if.win_col_index = '0;
    in_if.channel_index = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_edge_cases();
    test_crop_2d();
    test_volume_3d();
    test_oversized_registers();
    test_zero_step();
    test_largest_volume();
    drain_results();

    if (mismatch_count == 0 && pixel_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
